>>> sv/lcdnw_pkg.sv
// lcdnw_pkg: shared types and constants of the character lcd nibble write sequencer
// no dependencies
`timescale 1ns / 1ps

package lcdnw_pkg;

   typedef enum logic [2:0] {
      CMD_INSTR  = 3'd0,
      CMD_CHAR   = 3'd1,
      CMD_BYTE3  = 3'd2,
      CMD_DEC    = 3'd3,
      CMD_CURSOR = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEND,
      S_WRAP,
      S_MINUS,
      S_DIG_RUN,
      S_DIG_SEND
   } state_type;

   localparam logic [7:0] LINE1_BASE  = 8'h80;
   localparam logic [7:0] LINE2_BASE  = 8'hC0;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   localparam logic [2:0] POW_ONES    = 3'd0;
   localparam logic [2:0] POW_HUNDRED = 3'd2;
   localparam logic [2:0] POW_TOP     = 3'd4;

   // control from the sequencer to the digit unit
   typedef struct packed {
      logic        load;
      logic [15:0] value;
      logic        run;
      logic [2:0]  pow_sel;
   } dig_ctl_type;

   // status from the digit unit
   typedef struct packed {
      logic       busy;
      logic [3:0] digit;
   } dig_sts_type;

   // one byte handed to the nibble emitter
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       rs;
      logic       last;
   } emit_req_type;

   function automatic logic [13:0] pow10(input logic [2:0] sel);
      logic [13:0] p;
      unique case (sel)
         3'd0: p = 14'd1;
         3'd1: p = 14'd10;
         3'd2: p = 14'd100;
         3'd3: p = 14'd1000;
         3'd4: p = 14'd10000;
         default: p = 14'd1;
      endcase
      return p;
   endfunction

endpackage

>>> sv/lcdnw_digit.sv
// lcdnw_digit: shared compare and subtract unit, one decimal digit by repeated subtraction
// depends on lcdnw_pkg
`timescale 1ns / 1ps

module lcdnw_digit (
   input  logic                  clock,
   input  logic                  reset,
   input  lcdnw_pkg::dig_ctl_type ctl,
   output lcdnw_pkg::dig_sts_type sts
);

   logic [15:0] rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [2:0]  pow_ff, pow_in;
   logic        busy_ff, busy_in;
   logic [15:0] pow_val;
   logic        ge;

   assign pow_val = {2'b00, lcdnw_pkg::pow10(pow_ff)};
   assign ge      = rem_ff >= pow_val;

   always_comb begin
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      pow_in  = pow_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         rem_in = ctl.value;
      end
      if (ctl.run) begin
         cnt_in  = 4'd0;
         pow_in  = ctl.pow_sel;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - pow_val;
            cnt_in = cnt_ff + 4'd1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      pow_ff <= pow_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.digit = cnt_ff;

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !ctl.run |-> cnt_ff <= 4'd9)
      else $error("digit count out of range");

endmodule

>>> sv/lcdnw_emit.sv
// lcdnw_emit: splits one byte into a high then a low nibble beat on the result channel
// depends on lcdnw_pkg
`timescale 1ns / 1ps

module lcdnw_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdnw_pkg::emit_req_type req,
   output logic                    ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_nibble,
   output logic                    rsp_register_select,
   output logic                    rsp_last
);

   logic [7:0] data_ff;
   logic       rs_ff;
   logic       last_ff;
   logic       full_ff, full_in;
   logic       low_ff, low_in;
   logic       take;

   assign ready = !full_ff;
   assign take  = req.valid && !full_ff;

   always_comb begin
      full_in = full_ff;
      low_in  = low_ff;
      if (take) begin
         full_in = 1'b1;
         low_in  = 1'b0;
      end else if (full_ff && rsp_ready) begin
         if (low_ff) begin
            full_in = 1'b0;
         end else begin
            low_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         low_ff  <= 1'b0;
      end else begin
         full_ff <= full_in;
         low_ff  <= low_in;
      end
      if (take) begin
         data_ff <= req.data;
         rs_ff   <= req.rs;
         last_ff <= req.last;
      end
   end

   assign rsp_valid           = full_ff;
   assign rsp_nibble          = low_ff ? data_ff[3:0] : data_ff[7:4];
   assign rsp_register_select = rs_ff;
   assign rsp_last            = low_ff && last_ff;

   a_last_low_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !low_ff |-> !rsp_last)
      else $error("last flagged on a high nibble");

endmodule

>>> sv/char_lcd_nibble_write_sequencer.sv
// char_lcd_nibble_write_sequencer: top level, request decoder and byte sequencer
// depends on lcdnw_pkg, lcdnw_digit, lcdnw_emit
//
// usage:
//   req_ channel: one request beat per command (instruction byte, character,
//   three-digit byte, signed decimal, cursor move). req_ready is high only
//   while the sequencer is idle; it goes idle once the last byte of a request
//   is loaded into the nibble emitter, so the next request can overlap it.
//   rsp_ channel: one beat per nibble, high nibble first, rsp_last on the
//   final nibble of a request. unknown commands give no beats.
//   each byte is loaded into the nibble emitter and then leaves as two
//   rsp beats; the emitter takes no new byte until both beats are taken.
//   numbers are converted digit by digit in a shared subtract unit, each
//   digit by repeated subtraction, so a larger digit takes longer; the
//   leading zeros of a signed decimal are suppressed, and it gives up to
//   six bytes, a three-digit byte always three.
//   reset clears the string character count and the wrap flag and empties
//   the emitter. when the receiver stalls, the current nibble is held and
//   the sequencer waits; nothing is dropped.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer #(
   parameter int LINE_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_byte_value,
   input  logic signed [15:0] req_number_value,
   input  logic [1:0]  req_row,
   input  logic [4:0]  req_column,
   input  logic        req_string_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_register_select,
   output logic        rsp_last
);

   localparam int CW = $clog2(LINE_CHARS + 1);

   lcdnw_pkg::state_type    state_ff, state_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    rs_ff, rs_in;
   logic [2:0]              pow_ff, pow_in;
   logic                    started_ff, started_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    wrapped_ff, wrapped_in;

   lcdnw_pkg::dig_ctl_type  dig_ctl;
   lcdnw_pkg::dig_sts_type  dig_sts;
   lcdnw_pkg::emit_req_type emit_req;
   logic                    emit_ready;

   logic                    accept;
   logic [CW-1:0]           count0;
   logic                    wrapped0;
   logic [15:0]             mag;
   logic                    col_ok;
   logic [7:0]              cursor_addr;
   logic                    suppress;

   assign req_ready = state_ff == lcdnw_pkg::S_IDLE;
   assign accept    = req_valid && req_ready;

   assign count0   = req_string_start ? '0 : count_ff;
   assign wrapped0 = req_string_start ? 1'b0 : wrapped_ff;
   assign mag      = req_number_value[15] ? 16'd0 - 16'(req_number_value)
                                          : 16'(req_number_value);
   assign col_ok   = (req_column != 5'd0) && ({1'b0, req_column} <= 6'(LINE_CHARS));
   always_comb begin
      if (!col_ok || (req_row != 2'd1 && req_row != 2'd2)) begin
         cursor_addr = lcdnw_pkg::LINE1_BASE;
      end else if (req_row == 2'd1) begin
         cursor_addr = lcdnw_pkg::LINE1_BASE + {3'b000, req_column} - 8'd1;
      end else begin
         cursor_addr = lcdnw_pkg::LINE2_BASE + {3'b000, req_column} - 8'd1;
      end
   end

   assign suppress = !started_ff && (dig_sts.digit == 4'd0) &&
                     (pow_ff != lcdnw_pkg::POW_ONES);

   always_comb begin
      state_in   = state_ff;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      pow_in     = pow_ff;
      started_in = started_ff;
      count_in   = count_ff;
      wrapped_in = wrapped_ff;
      dig_ctl    = '0;
      emit_req   = '0;
      unique case (state_ff)
         lcdnw_pkg::S_IDLE: begin
            if (accept) begin
               unique case (lcdnw_pkg::cmd_type'(req_command))
                  lcdnw_pkg::CMD_INSTR: begin
                     byte_in  = req_byte_value;
                     rs_in    = 1'b0;
                     state_in = lcdnw_pkg::S_SEND;
                  end
                  lcdnw_pkg::CMD_CHAR: begin
                     byte_in    = req_byte_value;
                     rs_in      = 1'b1;
                     count_in   = count0;
                     wrapped_in = wrapped0;
                     state_in   = lcdnw_pkg::S_SEND;
                     if (count0 >= CW'(LINE_CHARS)) begin
                        if (!wrapped0) begin
                           wrapped_in = 1'b1;
                           state_in   = lcdnw_pkg::S_WRAP;
                        end
                     end else begin
                        count_in = count0 + 1'b1;
                     end
                  end
                  lcdnw_pkg::CMD_BYTE3: begin
                     dig_ctl.load    = 1'b1;
                     dig_ctl.value   = {8'd0, req_byte_value};
                     dig_ctl.run     = 1'b1;
                     dig_ctl.pow_sel = lcdnw_pkg::POW_HUNDRED;
                     pow_in          = lcdnw_pkg::POW_HUNDRED;
                     started_in      = 1'b1;
                     state_in        = lcdnw_pkg::S_DIG_RUN;
                  end
                  lcdnw_pkg::CMD_DEC: begin
                     dig_ctl.load    = 1'b1;
                     dig_ctl.value   = mag;
                     dig_ctl.run     = 1'b1;
                     dig_ctl.pow_sel = lcdnw_pkg::POW_TOP;
                     pow_in          = lcdnw_pkg::POW_TOP;
                     started_in      = 1'b0;
                     state_in        = req_number_value[15] ? lcdnw_pkg::S_MINUS
                                                            : lcdnw_pkg::S_DIG_RUN;
                  end
                  lcdnw_pkg::CMD_CURSOR: begin
                     byte_in  = cursor_addr;
                     rs_in    = 1'b0;
                     state_in = lcdnw_pkg::S_SEND;
                  end
                  default: begin
                     state_in = lcdnw_pkg::S_IDLE;
                  end
               endcase
            end
         end
         lcdnw_pkg::S_SEND: begin
            emit_req = '{valid: 1'b1, data: byte_ff, rs: rs_ff, last: 1'b1};
            if (emit_ready) begin
               state_in = lcdnw_pkg::S_IDLE;
            end
         end
         lcdnw_pkg::S_WRAP: begin
            emit_req = '{valid: 1'b1, data: lcdnw_pkg::LINE2_BASE, rs: 1'b0, last: 1'b0};
            if (emit_ready) begin
               state_in = lcdnw_pkg::S_SEND;
            end
         end
         lcdnw_pkg::S_MINUS: begin
            emit_req = '{valid: 1'b1, data: lcdnw_pkg::ASCII_MINUS, rs: 1'b1, last: 1'b0};
            if (emit_ready) begin
               state_in = lcdnw_pkg::S_DIG_RUN;
            end
         end
         lcdnw_pkg::S_DIG_RUN: begin
            if (!dig_sts.busy) begin
               if (suppress) begin
                  // leading zero, move on to the next power
                  pow_in          = pow_ff - 3'd1;
                  dig_ctl.run     = 1'b1;
                  dig_ctl.pow_sel = pow_ff - 3'd1;
               end else begin
                  started_in = 1'b1;
                  state_in   = lcdnw_pkg::S_DIG_SEND;
               end
            end
         end
         lcdnw_pkg::S_DIG_SEND: begin
            emit_req = '{valid: 1'b1,
                         data: lcdnw_pkg::ASCII_ZERO + {4'd0, dig_sts.digit},
                         rs: 1'b1,
                         last: pow_ff == lcdnw_pkg::POW_ONES};
            if (emit_ready) begin
               if (pow_ff == lcdnw_pkg::POW_ONES) begin
                  state_in = lcdnw_pkg::S_IDLE;
               end else begin
                  pow_in          = pow_ff - 3'd1;
                  dig_ctl.run     = 1'b1;
                  dig_ctl.pow_sel = pow_ff - 3'd1;
                  state_in        = lcdnw_pkg::S_DIG_RUN;
               end
            end
         end
         default: begin
            state_in = lcdnw_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lcdnw_pkg::S_IDLE;
         count_ff   <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wrapped_ff <= wrapped_in;
      end
      byte_ff    <= byte_in;
      rs_ff      <= rs_in;
      pow_ff     <= pow_in;
      started_ff <= started_in;
   end

   lcdnw_digit u_digit (
      .clock (clock),
      .reset (reset),
      .ctl   (dig_ctl),
      .sts   (dig_sts)
   );

   lcdnw_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .req                 (emit_req),
      .ready               (emit_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_nibble          (rsp_nibble),
      .rsp_register_select (rsp_register_select),
      .rsp_last            (rsp_last)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LINE_CHARS))
      else $error("string count above line length");

   a_wrap_full_line: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |-> count_ff == CW'(LINE_CHARS))
      else $error("wrap flag set before the line filled");

   a_digit_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcdnw_pkg::S_DIG_SEND |-> !dig_sts.busy)
      else $error("digit sent while the unit is busy");

endmodule
